[src/tmc_pkg.sv]
// Shared types, codes and constants for the tach counter and drive controller.
// Used by tmc_update and the top level tacho_motor_angle_time_control.
package tmc_pkg;

  localparam int MOTOR_COUNT_DEF = 3;

  // Fixed field widths
  localparam int CMD_W = 3;
  localparam int IDX_W = 2;
  localparam int CNT_W = 32;
  localparam int SPD_W = 8;

  localparam logic signed [SPD_W-1:0] SPEED_MAX = 8'sd100;
  localparam logic signed [SPD_W-1:0] SPEED_MIN = -8'sd100;

  // Command codes; 6 and 7 are unused and act like a read
  typedef enum logic [CMD_W-1:0] {
    CMD_TACH      = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_ROTATE    = 3'd2,
    CMD_ROT_ANGLE = 3'd3,
    CMD_ROT_TIME  = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_CONT  = 2'd1,
    MODE_ANGLE = 2'd2,
    MODE_TIME  = 2'd3
  } mode_t;

  // One motor's stored state
  typedef struct packed {
    mode_t            mode;
    logic             brake;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] target;
  } entry_t;

  localparam entry_t ENTRY_RST = '{mode: MODE_STOP, brake: 1'b1, count: '0, target: '0};

  // One request as held in the read stage
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic                    tach;
    logic                    dir;
    logic signed [SPD_W-1:0] speed;
    logic [CNT_W-1:0]        amount;
    logic                    brake;
    logic [CNT_W-1:0]        now;
  } req_t;

  // Result fields other than the motor index
  typedef struct packed {
    logic                    drive_update;
    logic signed [SPD_W-1:0] drive_speed;
    logic                    drive_brake;
    logic [CNT_W-1:0]        tach_count;
    mode_t                   motor_mode;
  } res_t;

  // Clamp a requested speed to +/-100
  function automatic logic signed [SPD_W-1:0] sat_speed(input logic signed [SPD_W-1:0] s);
    logic signed [SPD_W-1:0] v;
    v = s;
    if (s > SPEED_MAX) v = SPEED_MAX;
    else if (s < SPEED_MIN) v = SPEED_MIN;
    return v;
  endfunction

endpackage

[src/tmc_update.sv]
// Modify step of the per-motor read-modify-write: new entry and result.
// Depends on tmc_pkg.
module tmc_update (
  input  tmc_pkg::req_t   req,
  input  logic            in_range,
  input  tmc_pkg::entry_t cur,
  output tmc_pkg::entry_t entry_nxt,
  output tmc_pkg::res_t   res
);
  import tmc_pkg::*;

  logic signed [SPD_W-1:0] spd;
  logic [CNT_W-1:0]        count_step;
  logic                    auto_stop;

  assign spd        = sat_speed(req.speed);
  assign count_step = (req.tach != req.dir) ? cur.count + 1'b1 : cur.count - 1'b1;
  assign auto_stop  = ((cur.mode == MODE_ANGLE) && (count_step == cur.target)) ||
                      ((cur.mode == MODE_TIME) && (req.now >= cur.target));

  // Command decode
  always_comb begin
    entry_nxt        = cur;
    res.drive_update = 1'b0;
    res.drive_speed  = '0;
    res.drive_brake  = 1'b0;
    unique case (cmd_t'(req.cmd))
      CMD_TACH: begin
        entry_nxt.count = count_step;
        if (auto_stop) begin
          entry_nxt.mode   = MODE_STOP;
          res.drive_update = 1'b1;
          res.drive_brake  = cur.brake;
        end
      end
      CMD_STOP: begin
        entry_nxt.mode   = MODE_STOP;
        res.drive_update = 1'b1;
        res.drive_brake  = req.brake;
      end
      CMD_ROTATE: begin
        entry_nxt.mode   = MODE_CONT;
        res.drive_update = 1'b1;
        res.drive_speed  = spd;
      end
      CMD_ROT_ANGLE, CMD_ROT_TIME: begin
        res.drive_update = 1'b1;
        if (spd == '0) begin
          // zero speed is a plain stop
          entry_nxt.mode  = MODE_STOP;
          res.drive_brake = req.brake;
        end else begin
          if (cmd_t'(req.cmd) == CMD_ROT_ANGLE) begin
            entry_nxt.target = spd[SPD_W-1] ? cur.count - req.amount : cur.count + req.amount;
            entry_nxt.mode   = MODE_ANGLE;
          end else begin
            entry_nxt.target = req.now + req.amount;
            entry_nxt.mode   = MODE_TIME;
          end
          entry_nxt.brake = req.brake;
          res.drive_speed = spd;
        end
      end
      default: ;
    endcase
    res.tach_count = entry_nxt.count;
    res.motor_mode = entry_nxt.mode;
    // unknown motor: everything but the index reads zero
    if (!in_range) begin
      res = '0;
    end
  end

endmodule

[src/tacho_motor_angle_time_control.sv]
// Tach counter and drive controller for MOTOR_COUNT motors, state held in one memory.
// out_valid rises once a taken request has passed the memory read and the update.
// Throughput: one request per cycle while out_stall does not hold the output; the
// read/update/write loop on the motor state memory sets it, with forwarding for
// back-to-back requests on one motor.
// Reset: all motors read as stopped, brake set, count and target zero (per-entry
// valid bits, no clearing pass); pipeline and output emptied.
module tacho_motor_angle_time_control #(
  parameter int MOTOR_COUNT = tmc_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [tmc_pkg::CMD_W-1:0]               in_command,
  input  logic [tmc_pkg::IDX_W-1:0]               in_motor_index,
  input  logic                                    in_tach_level,
  input  logic                                    in_dir_level,
  input  logic signed [tmc_pkg::SPD_W-1:0]        in_speed_request,
  input  logic [tmc_pkg::CNT_W-1:0]               in_amount,
  input  logic                                    in_brake_request,
  input  logic [tmc_pkg::CNT_W-1:0]               in_now_ms,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_drive_update,
  output logic [tmc_pkg::IDX_W-1:0]               out_drive_motor,
  output logic signed [tmc_pkg::SPD_W-1:0]        out_drive_speed,
  output logic                                    out_drive_brake,
  output logic [tmc_pkg::CNT_W-1:0]               out_tach_count,
  output logic [1:0]                              out_motor_mode
);
  import tmc_pkg::*;

  localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  // Motor state memory and per-entry valid bits
  entry_t                 mem [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] vld_r;

  // Read stage
  logic            s1_valid_r;
  req_t            s1_req_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic            s1_inr_r;
  entry_t          rd_data_r;
  logic            rd_vld_r;
  logic            fwd_r;
  entry_t          fwd_data_r;

  // Output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  res_t             out_res_r;

  logic            in_acc;
  logic            out_take;
  logic            s1_adv;
  logic [IW-1:0]   in_idx_ext;
  logic [IW-1:0]   s1_idx_ext;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            in_inr;
  logic            wr_en;
  entry_t          cur;
  entry_t          entry_nxt;
  res_t            res;
  req_t            in_req;

  // Handshake: a request may enter while a result waits, if the read stage is free
  assign out_take = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_take;
  assign in_stall = s1_valid_r && !out_take;
  assign in_acc   = in_valid && !in_stall;

  assign in_idx_ext = IW'(in_motor_index);
  assign s1_idx_ext = IW'(s1_idx_r);
  assign rd_addr    = in_idx_ext[AW-1:0];
  assign wr_addr    = s1_idx_ext[AW-1:0];
  assign in_inr     = 32'(in_motor_index) < 32'(MOTOR_COUNT);
  assign wr_en      = s1_adv && s1_inr_r;

  assign in_req = '{cmd: in_command, tach: in_tach_level, dir: in_dir_level,
                    speed: in_speed_request, amount: in_amount,
                    brake: in_brake_request, now: in_now_ms};

  // Current entry: forwarded write, stored value, or reset value
  assign cur = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : ENTRY_RST);

  tmc_update u_update (
    .req       (s1_req_r),
    .in_range  (s1_inr_r),
    .cur       (cur),
    .entry_nxt (entry_nxt),
    .res       (res)
  );

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= entry_nxt;
    end
    if (in_acc && in_inr) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      fwd_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_r <= in_inr && vld_r[rd_addr];
        // same motor written this edge: take the new entry
        fwd_r    <= wr_en && in_inr && (wr_addr == rd_addr);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r   <= in_req;
      s1_idx_r   <= in_motor_index;
      s1_inr_r   <= in_inr;
      fwd_data_r <= entry_nxt;
    end
    if (s1_adv) begin
      out_idx_r <= s1_idx_r;
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_update = out_res_r.drive_update;
  assign out_drive_motor  = out_idx_r;
  assign out_drive_speed  = out_res_r.drive_speed;
  assign out_drive_brake  = out_res_r.drive_brake;
  assign out_tach_count   = out_res_r.tach_count;
  assign out_motor_mode   = out_res_r.motor_mode;

endmodule
